[rtl/bpr_pkg.sv]
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types and constants of the BPR link cost evaluator: fixed-point
// format, saturation limits, shared arithmetic unit opcodes and state types.
// ----------------------------------------------------------------------------
package bpr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int BETA_MAX  = 15;

  // payload widths
  localparam int IDX_W   = 16;
  localparam int IN_W    = 32;
  localparam int BETA_W  = 4;
  localparam int OUT_W   = 48;
  localparam int TOT_W   = 63;
  localparam int STAT_W  = 2;

  // internal value width and shared unit sizes
  localparam int VAL_W   = 64;
  localparam int HALF_W  = 32;
  localparam int ACC_W   = 2 * VAL_W;
  localparam int DQ_W    = 63 + FRAC_BITS;
  localparam int CNT_W   = $clog2(DQ_W + 1);

  localparam logic [VAL_W-1:0] LIM   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] ONE   = VAL_W'(1) << FRAC_BITS;
  localparam logic [VAL_W-1:0] OUT48 = {{(VAL_W-OUT_W){1'b0}}, {OUT_W{1'b1}}};
  localparam logic [VAL_W-1:0] POS47 = {{(VAL_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] NEG47 = VAL_W'(1) << (OUT_W - 1);

  // iteration counts of the restoring divider
  localparam logic [CNT_W-1:0] DIV_N_RATIO = CNT_W'(HALF_W + FRAC_BITS);
  localparam logic [CNT_W-1:0] DIV_N_FX    = CNT_W'(DQ_W);
  localparam logic [CNT_W-1:0] DIV_N_INT   = CNT_W'(63);

  // multiplier partial product steps (four products plus one drain step)
  localparam logic [2:0] MUL_LAST_STEP = 3'd4;

  typedef enum logic [2:0] {
    OP_MUL_FX,
    OP_MUL_INT,
    OP_DIV_RATIO,
    OP_DIV_FX,
    OP_DIV_INT
  } alu_op_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIN,
    A_DONE
  } alu_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_R,
    S_POW,
    S_AP,
    S_TIME,
    S_ALT0,
    S_SPREV,
    S_SBETA,
    S_DT,
    S_TF,
    S_TAP,
    S_DIVT,
    S_FDT,
    S_SUM,
    S_FIN
  } seq_state_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_ZERO_CAP,
    ST_SAT
  } status_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_rsp_t;

endpackage

[rtl/bpr_in_if.sv]
// ----------------------------------------------------------------------------
// bpr_in_if
// Link descriptor channel: valid/ready handshake with one link per transfer.
// ----------------------------------------------------------------------------
interface bpr_in_if;
  logic                         valid;
  logic                         ready;
  logic [bpr_pkg::IDX_W-1:0]    link_index;
  logic [bpr_pkg::IN_W-1:0]     flow;
  logic [bpr_pkg::IN_W-1:0]     free_time;
  logic [bpr_pkg::IN_W-1:0]     alpha_coef;
  logic [bpr_pkg::BETA_W-1:0]   beta_exp;
  logic [bpr_pkg::IN_W-1:0]     link_capacity;
  logic                         last_link;

  modport source (
    output valid, link_index, flow, free_time, alpha_coef, beta_exp,
           link_capacity, last_link,
    input  ready
  );

  modport sink (
    input  valid, link_index, flow, free_time, alpha_coef, beta_exp,
           link_capacity, last_link,
    output ready
  );
endinterface

[rtl/bpr_out_if.sv]
// ----------------------------------------------------------------------------
// bpr_out_if
// Link cost result channel: valid/ready handshake with one result per transfer.
// ----------------------------------------------------------------------------
interface bpr_out_if;
  logic                              valid;
  logic                              ready;
  logic [bpr_pkg::IDX_W-1:0]         link_index_out;
  logic [bpr_pkg::OUT_W-1:0]         congested_time;
  logic [bpr_pkg::OUT_W-1:0]         half_slope;
  logic signed [bpr_pkg::OUT_W-1:0]  intercept;
  logic [bpr_pkg::TOT_W-1:0]         objective_total;
  logic                              total_valid;
  logic [bpr_pkg::STAT_W-1:0]        status;

  modport source (
    output valid, link_index_out, congested_time, half_slope, intercept,
           objective_total, total_valid, status,
    input  ready
  );

  modport sink (
    input  valid, link_index_out, congested_time, half_slope, intercept,
           objective_total, total_valid, status,
    output ready
  );
endinterface

[rtl/bpr_alu.sv]
// ----------------------------------------------------------------------------
// bpr_alu
// Shared multi-cycle arithmetic unit: 64x64 fixed-point or integer multiply
// from four 32x32 partial products, and a one-bit-per-cycle restoring divider.
// Results are clamped at 2^63-1 with a saturation flag.
// ----------------------------------------------------------------------------
module bpr_alu (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bpr_pkg::alu_req_t            req,
  input  logic [bpr_pkg::VAL_W-1:0]    opa,
  input  logic [bpr_pkg::VAL_W-1:0]    opb,
  output bpr_pkg::alu_rsp_t            rsp,
  output logic [bpr_pkg::VAL_W-1:0]    res
);

  bpr_pkg::alu_state_t state_r, state_nxt;
  bpr_pkg::alu_op_t    op_r;

  logic [bpr_pkg::VAL_W-1:0]   a_r, b_r;
  logic [2:0]                  step_r;
  logic [1:0]                  pk_r;
  logic [2*bpr_pkg::HALF_W-1:0] prod_r;
  logic [bpr_pkg::ACC_W-1:0]   acc_r;
  logic [bpr_pkg::DQ_W-1:0]    dq_r;
  logic [bpr_pkg::HALF_W-1:0]  rem_r, dvs_r;
  logic [bpr_pkg::CNT_W-1:0]   cnt_r;
  logic [bpr_pkg::VAL_W-1:0]   res_r;
  logic                        sat_r;

  logic                        req_div;
  logic [bpr_pkg::HALF_W-1:0]  a_half, b_half;
  logic [bpr_pkg::ACC_W-1:0]   pp_shifted;
  logic [bpr_pkg::HALF_W:0]    trial, diff;
  logic                        q_bit;
  logic [bpr_pkg::VAL_W-1:0]   fin_val;
  logic                        fin_ovf;

  assign req_div = (req.op == bpr_pkg::OP_DIV_RATIO) || (req.op == bpr_pkg::OP_DIV_FX) ||
                   (req.op == bpr_pkg::OP_DIV_INT);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpr_pkg::A_IDLE: begin
        if (req.start) state_nxt = req_div ? bpr_pkg::A_DIV : bpr_pkg::A_MUL;
      end
      bpr_pkg::A_MUL: begin
        if (step_r == bpr_pkg::MUL_LAST_STEP) state_nxt = bpr_pkg::A_FIN;
      end
      bpr_pkg::A_DIV: begin
        if (cnt_r == bpr_pkg::CNT_W'(1)) state_nxt = bpr_pkg::A_FIN;
      end
      bpr_pkg::A_FIN:  state_nxt = bpr_pkg::A_DONE;
      bpr_pkg::A_DONE: state_nxt = bpr_pkg::A_IDLE;
      default:         state_nxt = bpr_pkg::A_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = (state_r == bpr_pkg::A_DONE);
    rsp.sat  = sat_r;
    res      = res_r;
  end

  // partial product select: lo*lo, lo*hi, hi*lo, hi*hi
  assign a_half = step_r[1] ? a_r[bpr_pkg::VAL_W-1:bpr_pkg::HALF_W] : a_r[bpr_pkg::HALF_W-1:0];
  assign b_half = step_r[0] ? b_r[bpr_pkg::VAL_W-1:bpr_pkg::HALF_W] : b_r[bpr_pkg::HALF_W-1:0];

  always_comb begin
    case (pk_r)
      2'd0:    pp_shifted = {{bpr_pkg::VAL_W{1'b0}}, prod_r};
      2'd1,
      2'd2:    pp_shifted = {{bpr_pkg::HALF_W{1'b0}}, prod_r, {bpr_pkg::HALF_W{1'b0}}};
      default: pp_shifted = {prod_r, {bpr_pkg::VAL_W{1'b0}}};
    endcase
  end

  // restoring divide step
  assign trial = {rem_r, dq_r[bpr_pkg::DQ_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign q_bit = (trial >= {1'b0, dvs_r});

  // final clamp
  always_comb begin
    case (op_r)
      bpr_pkg::OP_MUL_FX: begin
        fin_ovf = |acc_r[bpr_pkg::ACC_W-1:63+bpr_pkg::FRAC_BITS];
        fin_val = {1'b0, acc_r[62+bpr_pkg::FRAC_BITS:bpr_pkg::FRAC_BITS]};
      end
      bpr_pkg::OP_MUL_INT: begin
        fin_ovf = |acc_r[bpr_pkg::ACC_W-1:63];
        fin_val = {1'b0, acc_r[62:0]};
      end
      default: begin
        fin_ovf = |dq_r[bpr_pkg::DQ_W-1:63];
        fin_val = {1'b0, dq_r[62:0]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpr_pkg::A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      bpr_pkg::A_IDLE: begin
        if (req.start) begin
          op_r   <= req.op;
          a_r    <= opa;
          b_r    <= opb;
          step_r <= 3'd0;
          acc_r  <= '0;
          rem_r  <= '0;
          dvs_r  <= opb[bpr_pkg::HALF_W-1:0];
          // dividend is left aligned so the quotient ends up right aligned
          if (req.op == bpr_pkg::OP_DIV_RATIO) begin
            dq_r  <= {opa[bpr_pkg::HALF_W-1:0], {(bpr_pkg::DQ_W-bpr_pkg::HALF_W){1'b0}}};
            cnt_r <= bpr_pkg::DIV_N_RATIO;
          end else begin
            dq_r  <= {opa[62:0], {bpr_pkg::FRAC_BITS{1'b0}}};
            cnt_r <= (req.op == bpr_pkg::OP_DIV_INT) ? bpr_pkg::DIV_N_INT : bpr_pkg::DIV_N_FX;
          end
        end
      end
      bpr_pkg::A_MUL: begin
        if (step_r != bpr_pkg::MUL_LAST_STEP) begin
          prod_r <= a_half * b_half;
          pk_r   <= step_r[1:0];
        end
        if (step_r != 3'd0) acc_r <= acc_r + pp_shifted;
        step_r <= step_r + 3'd1;
      end
      bpr_pkg::A_DIV: begin
        dq_r  <= {dq_r[bpr_pkg::DQ_W-2:0], q_bit};
        rem_r <= q_bit ? diff[bpr_pkg::HALF_W-1:0] : trial[bpr_pkg::HALF_W-1:0];
        cnt_r <= cnt_r - bpr_pkg::CNT_W'(1);
      end
      bpr_pkg::A_FIN: begin
        res_r <= fin_ovf ? bpr_pkg::LIM : fin_val;
        sat_r <= fin_ovf;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/bpr_link_cost_evaluator_core.sv]
// ----------------------------------------------------------------------------
// bpr_link_cost_evaluator_core
// Evaluates the BPR volume-delay function for one link per transfer: congested
// time, half slope, intercept and the Beckmann objective term, which is summed
// over a pass and returned on the link marked last. Inputs are unsigned
// Q16.16; outputs are Q32.16, the intercept signed, with saturation reported
// in status. One link at a time goes through a single shared unit (a 32x32
// multiplier building each 64x64 product from four partial products, and a
// restoring divider giving one quotient bit per cycle). The input is not ready
// while a link is evaluated and becomes ready in the same cycle that its
// result is registered. A finished result waits in an output register, and
// the next link is accepted while it waits; a result that is still waiting
// holds the next one back until it is taken.
// ----------------------------------------------------------------------------
module bpr_link_cost_evaluator_core (
  input  logic             clk,
  input  logic             rst_n,
  bpr_in_if.sink           in_ch,
  bpr_out_if.source        out_ch
);

  bpr_pkg::seq_state_t state_r, state_nxt;

  logic                            issued_r;
  logic [bpr_pkg::IDX_W-1:0]       idx_r;
  logic [bpr_pkg::IN_W-1:0]        f_r, t0_r, al_r, cap_r;
  logic [bpr_pkg::BETA_W-1:0]      beta_r, cnt_r;
  logic                            last_r, zc_r, sat_r;
  logic [bpr_pkg::VAL_W-1:0]       r_r, pw_r, prev_r, ap_r, time_r, tmp_r;
  logic [bpr_pkg::VAL_W-1:0]       dt_r, tf_r, fdt_r, acc_r;

  logic                            out_valid_r;
  logic [bpr_pkg::IDX_W-1:0]       out_idx_r;
  logic [bpr_pkg::OUT_W-1:0]       out_ct_r, out_hs_r, out_icpt_r;
  logic [bpr_pkg::TOT_W-1:0]       out_tot_r;
  logic                            out_tv_r;
  bpr_pkg::status_t                out_status_r;

  bpr_pkg::alu_req_t               alu_req;
  bpr_pkg::alu_rsp_t               alu_rsp;
  logic [bpr_pkg::VAL_W-1:0]       alu_a, alu_b, alu_res;

  logic                            accept, op_state, fin_go;
  logic [bpr_pkg::BETA_W-1:0]      beta_in;
  logic [bpr_pkg::VAL_W:0]         apone_sum;
  logic [bpr_pkg::VAL_W-1:0]       apone;
  logic                            apone_ovf;
  logic [bpr_pkg::VAL_W-1:0]       tsum, asum, icpt_mag;
  logic                            tsum_ovf, asum_ovf;
  logic [bpr_pkg::OUT_W-1:0]       ct_val, hs_val, icpt_val;
  logic                            ct_ovf, hs_ovf, icpt_ovf, time_ge;
  logic [bpr_pkg::VAL_W-1:0]       hs_full;
  logic                            fin_sat;
  bpr_pkg::status_t                status_val;

  assign accept  = in_ch.valid && in_ch.ready;
  assign beta_in = (int'(in_ch.beta_exp) > bpr_pkg::BETA_MAX) ?
                   bpr_pkg::BETA_W'(bpr_pkg::BETA_MAX) : in_ch.beta_exp;
  assign fin_go  = (state_r == bpr_pkg::S_FIN) && (!out_valid_r || out_ch.ready);

  bpr_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (alu_a),
    .opb   (alu_b),
    .rsp   (alu_rsp),
    .res   (alu_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpr_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.link_capacity == '0) ? bpr_pkg::S_TF : bpr_pkg::S_DIV_R;
        end
      end
      bpr_pkg::S_DIV_R: begin
        if (alu_rsp.done) state_nxt = (beta_r == '0) ? bpr_pkg::S_AP : bpr_pkg::S_POW;
      end
      bpr_pkg::S_POW: begin
        if (alu_rsp.done && cnt_r == bpr_pkg::BETA_W'(1)) state_nxt = bpr_pkg::S_AP;
      end
      bpr_pkg::S_AP: begin
        if (alu_rsp.done) state_nxt = bpr_pkg::S_TIME;
      end
      bpr_pkg::S_TIME: begin
        if (alu_rsp.done) state_nxt = (beta_r == '0) ? bpr_pkg::S_TF : bpr_pkg::S_ALT0;
      end
      bpr_pkg::S_ALT0: begin
        if (alu_rsp.done) state_nxt = bpr_pkg::S_SPREV;
      end
      bpr_pkg::S_SPREV: begin
        if (alu_rsp.done) state_nxt = bpr_pkg::S_SBETA;
      end
      bpr_pkg::S_SBETA: begin
        if (alu_rsp.done) state_nxt = bpr_pkg::S_DT;
      end
      bpr_pkg::S_DT: begin
        if (alu_rsp.done) state_nxt = bpr_pkg::S_TF;
      end
      bpr_pkg::S_TF: begin
        if (alu_rsp.done) state_nxt = zc_r ? bpr_pkg::S_SUM : bpr_pkg::S_TAP;
      end
      bpr_pkg::S_TAP: begin
        if (alu_rsp.done) state_nxt = bpr_pkg::S_DIVT;
      end
      bpr_pkg::S_DIVT: begin
        if (alu_rsp.done) state_nxt = (beta_r == '0) ? bpr_pkg::S_SUM : bpr_pkg::S_FDT;
      end
      bpr_pkg::S_FDT: begin
        if (alu_rsp.done) state_nxt = bpr_pkg::S_SUM;
      end
      bpr_pkg::S_SUM: state_nxt = bpr_pkg::S_FIN;
      bpr_pkg::S_FIN: begin
        if (fin_go) state_nxt = bpr_pkg::S_IDLE;
      end
      default: state_nxt = bpr_pkg::S_IDLE;
    endcase
  end

  // 1 + alpha*(f/c)^beta, saturated
  assign apone_sum = {1'b0, bpr_pkg::ONE} + {1'b0, ap_r};
  assign apone_ovf = (apone_sum > {1'b0, bpr_pkg::LIM});
  assign apone     = apone_ovf ? bpr_pkg::LIM : apone_sum[bpr_pkg::VAL_W-1:0];

  // outputs: shared unit request and operands, input ready
  always_comb begin
    op_state    = 1'b1;
    alu_req.op  = bpr_pkg::OP_MUL_FX;
    alu_a       = '0;
    alu_b       = '0;
    case (state_r)
      bpr_pkg::S_DIV_R: begin
        alu_req.op = bpr_pkg::OP_DIV_RATIO;
        alu_a      = {{(bpr_pkg::VAL_W-bpr_pkg::IN_W){1'b0}}, f_r};
        alu_b      = {{(bpr_pkg::VAL_W-bpr_pkg::IN_W){1'b0}}, cap_r};
      end
      bpr_pkg::S_POW: begin
        alu_a = pw_r;
        alu_b = r_r;
      end
      bpr_pkg::S_AP: begin
        alu_a = {{(bpr_pkg::VAL_W-bpr_pkg::IN_W){1'b0}}, al_r};
        alu_b = pw_r;
      end
      bpr_pkg::S_TIME: begin
        alu_a = {{(bpr_pkg::VAL_W-bpr_pkg::IN_W){1'b0}}, t0_r};
        alu_b = apone;
      end
      bpr_pkg::S_ALT0: begin
        alu_a = {{(bpr_pkg::VAL_W-bpr_pkg::IN_W){1'b0}}, al_r};
        alu_b = {{(bpr_pkg::VAL_W-bpr_pkg::IN_W){1'b0}}, t0_r};
      end
      bpr_pkg::S_SPREV: begin
        alu_a = tmp_r;
        alu_b = prev_r;
      end
      bpr_pkg::S_SBETA: begin
        alu_req.op = bpr_pkg::OP_MUL_INT;
        alu_a      = tmp_r;
        alu_b      = {{(bpr_pkg::VAL_W-bpr_pkg::BETA_W){1'b0}}, beta_r};
      end
      bpr_pkg::S_DT: begin
        alu_req.op = bpr_pkg::OP_DIV_FX;
        alu_a      = tmp_r;
        alu_b      = {{(bpr_pkg::VAL_W-bpr_pkg::IN_W){1'b0}}, cap_r};
      end
      bpr_pkg::S_TF: begin
        alu_a = {{(bpr_pkg::VAL_W-bpr_pkg::IN_W){1'b0}}, t0_r};
        alu_b = {{(bpr_pkg::VAL_W-bpr_pkg::IN_W){1'b0}}, f_r};
      end
      bpr_pkg::S_TAP: begin
        alu_a = tf_r;
        alu_b = ap_r;
      end
      bpr_pkg::S_DIVT: begin
        alu_req.op = bpr_pkg::OP_DIV_INT;
        alu_a      = tmp_r;
        alu_b      = {{(bpr_pkg::VAL_W-bpr_pkg::BETA_W){1'b0}}, beta_r} + bpr_pkg::VAL_W'(1);
      end
      bpr_pkg::S_FDT: begin
        alu_a = {{(bpr_pkg::VAL_W-bpr_pkg::IN_W){1'b0}}, f_r};
        alu_b = dt_r;
      end
      default: op_state = 1'b0;
    endcase
    alu_req.start = op_state && !issued_r;
    in_ch.ready   = (state_r == bpr_pkg::S_IDLE);
  end

  // beckmann term and pass sum
  assign tsum     = tf_r + tmp_r;
  assign tsum_ovf = (tsum > bpr_pkg::LIM);
  assign asum     = acc_r + tmp_r;
  assign asum_ovf = (asum > bpr_pkg::LIM);

  // output clamps
  assign ct_ovf   = (time_r > bpr_pkg::OUT48);
  assign ct_val   = ct_ovf ? bpr_pkg::OUT48[bpr_pkg::OUT_W-1:0] : time_r[bpr_pkg::OUT_W-1:0];
  assign hs_full  = dt_r >> 1;
  assign hs_ovf   = (hs_full > bpr_pkg::OUT48);
  assign hs_val   = hs_ovf ? bpr_pkg::OUT48[bpr_pkg::OUT_W-1:0] : hs_full[bpr_pkg::OUT_W-1:0];
  assign time_ge  = (time_r >= fdt_r);
  assign icpt_mag = time_ge ? (time_r - fdt_r) : (fdt_r - time_r);

  always_comb begin
    if (time_ge) begin
      icpt_ovf = (icpt_mag > bpr_pkg::POS47);
      icpt_val = icpt_ovf ? bpr_pkg::POS47[bpr_pkg::OUT_W-1:0] : icpt_mag[bpr_pkg::OUT_W-1:0];
    end else begin
      icpt_ovf = (icpt_mag > bpr_pkg::NEG47);
      icpt_val = icpt_ovf ? bpr_pkg::NEG47[bpr_pkg::OUT_W-1:0] :
                 (bpr_pkg::OUT_W'(0) - icpt_mag[bpr_pkg::OUT_W-1:0]);
    end
  end

  assign fin_sat = sat_r || ct_ovf || hs_ovf || icpt_ovf || asum_ovf;

  always_comb begin
    if (zc_r) status_val = bpr_pkg::ST_ZERO_CAP;
    else if (fin_sat) status_val = bpr_pkg::ST_SAT;
    else status_val = bpr_pkg::ST_OK;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpr_pkg::S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (alu_req.start) issued_r <= 1'b1;
      else if (alu_rsp.done) issued_r <= 1'b0;
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (fin_go) begin
        acc_r <= last_r ? '0 : (asum_ovf ? bpr_pkg::LIM : asum);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r  <= in_ch.link_index;
      f_r    <= in_ch.flow;
      t0_r   <= in_ch.free_time;
      al_r   <= in_ch.alpha_coef;
      cap_r  <= in_ch.link_capacity;
      last_r <= in_ch.last_link;
      zc_r   <= (in_ch.link_capacity == '0);
      beta_r <= beta_in;
      cnt_r  <= beta_in;
      sat_r  <= 1'b0;
      pw_r   <= bpr_pkg::ONE;
      prev_r <= bpr_pkg::ONE;
      ap_r   <= '0;
      dt_r   <= '0;
      fdt_r  <= '0;
      tmp_r  <= '0;
      time_r <= {{(bpr_pkg::VAL_W-bpr_pkg::IN_W){1'b0}}, in_ch.free_time};
    end else begin
      if (alu_req.start && state_r == bpr_pkg::S_TIME && apone_ovf) sat_r <= 1'b1;
      if (alu_rsp.done && alu_rsp.sat) sat_r <= 1'b1;
      if (state_r == bpr_pkg::S_SUM) begin
        tmp_r <= tsum_ovf ? bpr_pkg::LIM : tsum;
        if (tsum_ovf) sat_r <= 1'b1;
      end
      if (alu_rsp.done) begin
        case (state_r)
          bpr_pkg::S_DIV_R: r_r <= alu_res;
          bpr_pkg::S_POW: begin
            prev_r <= pw_r;
            pw_r   <= alu_res;
            cnt_r  <= cnt_r - bpr_pkg::BETA_W'(1);
          end
          bpr_pkg::S_AP:    ap_r   <= alu_res;
          bpr_pkg::S_TIME:  time_r <= alu_res;
          bpr_pkg::S_ALT0,
          bpr_pkg::S_SPREV,
          bpr_pkg::S_SBETA,
          bpr_pkg::S_TAP,
          bpr_pkg::S_DIVT:  tmp_r  <= alu_res;
          bpr_pkg::S_DT:    dt_r   <= alu_res;
          bpr_pkg::S_TF:    tf_r   <= alu_res;
          bpr_pkg::S_FDT:   fdt_r  <= alu_res;
          default: begin
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_idx_r    <= idx_r;
      out_ct_r     <= ct_val;
      out_hs_r     <= hs_val;
      out_icpt_r   <= icpt_val;
      out_tot_r    <= last_r ? (asum_ovf ? bpr_pkg::LIM[bpr_pkg::TOT_W-1:0] :
                                asum[bpr_pkg::TOT_W-1:0]) : '0;
      out_tv_r     <= last_r;
      out_status_r <= status_val;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.link_index_out  = out_idx_r;
  assign out_ch.congested_time  = out_ct_r;
  assign out_ch.half_slope      = out_hs_r;
  assign out_ch.intercept       = out_icpt_r;
  assign out_ch.objective_total = out_tot_r;
  assign out_ch.total_valid     = out_tv_r;
  assign out_ch.status          = out_status_r;

`ifndef ASSERT_OFF
  // a link occupies the block until its result is formed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("input ready right after a transfer");

  // the shared unit only answers requests that were issued
  a_alu_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> issued_r)
    else $error("shared unit result without a request");

  // the pass sum is only shown on the last link
  a_total_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.total_valid) |-> (out_ch.objective_total == '0))
    else $error("objective total shown on a link that is not last");

  // the running sum is cleared once the result of the last link is registered
  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && last_r) |=> (acc_r == '0))
    else $error("pass sum not cleared after last link");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BPR link cost evaluator. A table of corner links
// runs first, then randomized links: mostly plausible networks, plus zero
// capacity, small values and unrestricted bit patterns. Each accepted link is
// evaluated by a bit-exact fixed-point cost calculator kept here; its result,
// or a corner row's fixed cost, is queued and compared field by field with
// the block's result. Both channels idle at random in two of three phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CORNERS  = 20;
  localparam int RANDOM_LINKS = 650;
  localparam int DRAIN_CYCLES = 500;
  localparam int CYCLE_LIMIT  = 1_500_000;

  typedef struct packed {
    logic [bpr_pkg::IDX_W-1:0]  link_index;
    logic [bpr_pkg::IN_W-1:0]   flow;
    logic [bpr_pkg::IN_W-1:0]   free_time;
    logic [bpr_pkg::IN_W-1:0]   alpha_coef;
    logic [bpr_pkg::BETA_W-1:0] beta_exp;
    logic [bpr_pkg::IN_W-1:0]   link_capacity;
    logic                       last_link;
  } link_desc_t;

  typedef struct packed {
    logic [bpr_pkg::IDX_W-1:0] link_index;
    logic [bpr_pkg::OUT_W-1:0] congested_time;
    logic [bpr_pkg::OUT_W-1:0] half_slope;
    logic [bpr_pkg::OUT_W-1:0] intercept;
    logic [bpr_pkg::TOT_W-1:0] objective_total;
    logic                      total_valid;
    bpr_pkg::status_t          status;
  } link_cost_t;

  typedef struct packed {
    link_desc_t desc;
    logic       fixed_cost;
    link_cost_t cost;
  } corner_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bpr_in_if  in_ch ();
  bpr_out_if out_ch ();

  bpr_link_cost_evaluator_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  link_cost_t  pending_costs [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 24;
  int unsigned snk_idle_pct = 62;

  // calculator state
  logic        sat_hit;
  logic [63:0] pass_objective = '0;

  // first rows carry costs that follow directly from the definition
  corner_row_t corner_links [0:NUM_CORNERS-1] = '{
    '{'{16'h0001, 32'h0, 32'h0001_0000, 32'h0, 4'd0, 32'h0, 1'b0}, 1'b1,
      '{16'h0001, 48'h1_0000, 48'h0, 48'h1_0000, 63'h0, 1'b0, bpr_pkg::ST_ZERO_CAP}},
    '{'{16'h0000, 32'h0, 32'h0, 32'h0, 4'd0, 32'h0001_0000, 1'b1}, 1'b1,
      '{16'h0000, 48'h0, 48'h0, 48'h0, 63'h0, 1'b1, bpr_pkg::ST_OK}},
    '{'{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 32'h0, 1'b1}, 1'b1,
      '{16'hFFFF, 48'hFFFF_FFFF, 48'h0, 48'hFFFF_FFFF, 63'hFFFF_FFFE_0000, 1'b1,
        bpr_pkg::ST_ZERO_CAP}},
    '{'{16'h0002, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 32'h1, 1'b0}, 1'b1,
      '{16'h0002, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h0, 63'h0, 1'b0,
        bpr_pkg::ST_SAT}},
    '{'{16'h0003, 32'h0001_0000, 32'h0001_0000, 32'h0000_2666, 4'd0, 32'h0001_0000, 1'b0},
      1'b0, '0},
    '{'{16'h0004, 32'h0000_8000, 32'h000A_0000, 32'h0000_2666, 4'd4, 32'h0001_0000, 1'b0},
      1'b0, '0},
    // flow twice capacity drives the intercept negative
    '{'{16'h0005, 32'h0002_0000, 32'h000A_0000, 32'h0001_0000, 4'd4, 32'h0001_0000, 1'b0},
      1'b0, '0},
    '{'{16'h0006, 32'h0064_0000, 32'h001E_0000, 32'h0000_8000, 4'd1, 32'h0032_0000, 1'b1},
      1'b0, '0},
    '{'{16'h0007, 32'h0300_0000, 32'h0005_0000, 32'h0000_4000, 4'd2, 32'h0200_0000, 1'b0},
      1'b0, '0},
    '{'{16'h0008, 32'h0000_C000, 32'h0002_8000, 32'h0000_2666, 4'd8, 32'h0001_0000, 1'b0},
      1'b0, '0},
    '{'{16'h0009, 32'h0001_8000, 32'h0001_0000, 32'h0000_2666, 4'd15, 32'h0001_0000, 1'b0},
      1'b0, '0},
    '{'{16'h000A, 32'h0, 32'h0010_0000, 32'h0001_0000, 4'd5, 32'h0004_0000, 1'b0},
      1'b0, '0},
    // zero flow with beta one still has a slope
    '{'{16'h000B, 32'h0, 32'h0010_0000, 32'h0001_0000, 4'd1, 32'h0004_0000, 1'b0},
      1'b0, '0},
    '{'{16'h000C, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_2666, 4'd7, 32'hFFFF_FFFF, 1'b1},
      1'b0, '0},
    '{'{16'h000D, 32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 4'd3, 32'h0000_0001, 1'b0},
      1'b0, '0},
    // two maximal terms push the pass sum into saturation
    '{'{16'h000E, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 32'h0001_0000, 1'b0},
      1'b0, '0},
    '{'{16'h000F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 32'h0001_0000, 1'b0},
      1'b0, '0},
    '{'{16'h0010, 32'h0001_0000, 32'h0001_0000, 32'h0, 4'd3, 32'h0001_0000, 1'b1},
      1'b0, '0},
    '{'{16'h0011, 32'h0008_0000, 32'h0003_0000, 32'h0000_2666, 4'd4, 32'h0010_0000, 1'b1},
      1'b0, '0},
    '{'{16'h8000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 4'd9, 32'h8000_0000, 1'b0},
      1'b0, '0}
  };

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, bpr_pkg::LIM}) begin
      sat_hit = 1'b1;
      return bpr_pkg::LIM;
    end
    return s[63:0];
  endfunction

  // full product, floored by the fraction bits
  function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> bpr_pkg::FRAC_BITS;
    if (p > {64'd0, bpr_pkg::LIM}) begin
      sat_hit = 1'b1;
      return bpr_pkg::LIM;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] div_q(input logic [63:0] x, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] rem;
    q = x / d;
    rem = x % d;
    if (q > (bpr_pkg::LIM >> bpr_pkg::FRAC_BITS)) begin
      sat_hit = 1'b1;
      return bpr_pkg::LIM;
    end
    return add_sat(q << bpr_pkg::FRAC_BITS, (rem << bpr_pkg::FRAC_BITS) / d);
  endfunction

  function automatic link_cost_t eval_link_cost(input link_desc_t l);
    logic [63:0] f, t0, al, cap, ratio, pw, prev, ap, tm, dt, s;
    logic [63:0] tf, term, fdt, gap, icpt, ct, hs;
    logic [63:0] beta;
    logic        zc;
    int unsigned i;
    link_cost_t  r;
    f = 64'(l.flow);
    t0 = 64'(l.free_time);
    al = 64'(l.alpha_coef);
    cap = 64'(l.link_capacity);
    beta = 64'(l.beta_exp);
    if (beta > 64'(bpr_pkg::BETA_MAX)) beta = 64'(bpr_pkg::BETA_MAX);
    zc = (cap == 64'd0);
    sat_hit = 1'b0;
    dt = '0;
    ap = '0;
    if (zc) begin
      tm = t0;
    end else begin
      ratio = (f << bpr_pkg::FRAC_BITS) / cap;
      pw = bpr_pkg::ONE;
      prev = bpr_pkg::ONE;
      for (i = 0; i < beta; i++) begin
        prev = pw;
        pw = mul_q(pw, ratio);
      end
      ap = mul_q(al, pw);
      tm = mul_q(t0, add_sat(bpr_pkg::ONE, ap));
      if (beta > 64'd0) begin
        s = mul_q(mul_q(al, t0), prev);
        if (s > bpr_pkg::LIM / beta) begin
          sat_hit = 1'b1;
          s = bpr_pkg::LIM;
        end else begin
          s = s * beta;
        end
        dt = div_q(s, cap);
      end
    end
    tf = mul_q(t0, f);
    term = add_sat(tf, mul_q(tf, ap) / (beta + 64'd1));
    fdt = mul_q(f, dt);
    ct = tm;
    if (ct > bpr_pkg::OUT48) begin
      ct = bpr_pkg::OUT48;
      sat_hit = 1'b1;
    end
    hs = dt >> 1;
    if (hs > bpr_pkg::OUT48) begin
      hs = bpr_pkg::OUT48;
      sat_hit = 1'b1;
    end
    if (tm >= fdt) begin
      icpt = tm - fdt;
      if (icpt > bpr_pkg::POS47) begin
        icpt = bpr_pkg::POS47;
        sat_hit = 1'b1;
      end
    end else begin
      gap = fdt - tm;
      if (gap > bpr_pkg::NEG47) begin
        gap = bpr_pkg::NEG47;
        sat_hit = 1'b1;
      end
      icpt = (64'd0 - gap) & bpr_pkg::OUT48;
    end
    pass_objective = add_sat(pass_objective, term);
    r.link_index = l.link_index;
    r.congested_time = ct[bpr_pkg::OUT_W-1:0];
    r.half_slope = hs[bpr_pkg::OUT_W-1:0];
    r.intercept = icpt[bpr_pkg::OUT_W-1:0];
    if (l.last_link) begin
      r.objective_total = pass_objective[bpr_pkg::TOT_W-1:0];
      r.total_valid = 1'b1;
      pass_objective = '0;
    end else begin
      r.objective_total = '0;
      r.total_valid = 1'b0;
    end
    r.status = zc ? bpr_pkg::ST_ZERO_CAP : (sat_hit ? bpr_pkg::ST_SAT : bpr_pkg::ST_OK);
    return r;
  endfunction

  function automatic link_desc_t rand_link();
    link_desc_t  l;
    logic [63:0] scaled;
    int unsigned pick;
    pick = $urandom_range(99);
    l.link_index = 16'($urandom);
    l.beta_exp = 4'($urandom_range(15));
    l.last_link = ($urandom_range(9) == 0);
    if (pick < 55) begin
      // plausible link: flow up to three times capacity, modest alpha
      l.link_capacity = $urandom_range(32'h0FFF_FFFF, 32'h10);
      scaled = (64'(l.link_capacity) * 64'($urandom_range(3 * 65536))) >> bpr_pkg::FRAC_BITS;
      l.flow = scaled[31:0];
      l.free_time = $urandom_range(32'h00FF_FFFF, 1);
      l.alpha_coef = $urandom_range(32'h0002_0000);
    end else if (pick < 65) begin
      l.flow = $urandom;
      l.free_time = $urandom;
      l.alpha_coef = $urandom;
      l.link_capacity = '0;
    end else if (pick < 80) begin
      l.flow = $urandom_range(32'h000F_FFFF);
      l.free_time = $urandom_range(32'h000F_FFFF);
      l.alpha_coef = $urandom_range(32'h000F_FFFF);
      l.link_capacity = $urandom_range(32'h000F_FFFF);
    end else begin
      l.flow = $urandom;
      l.free_time = $urandom;
      l.alpha_coef = $urandom;
      l.link_capacity = $urandom;
    end
    return l;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_link(input link_desc_t l, input logic fixed_cost,
                           input link_cost_t cost);
    link_cost_t predicted;
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.link_index <= l.link_index;
    in_ch.flow <= l.flow;
    in_ch.free_time <= l.free_time;
    in_ch.alpha_coef <= l.alpha_coef;
    in_ch.beta_exp <= l.beta_exp;
    in_ch.link_capacity <= l.link_capacity;
    in_ch.last_link <= l.last_link;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // calculator runs on every transfer so the pass sum stays in step
    predicted = eval_link_cost(l);
    pending_costs.insert(pending_costs.size(), fixed_cost ? cost : predicted);
  endtask

  task automatic check_cost();
    link_cost_t want;
    if (pending_costs.size() == 0) begin
      report_mismatch("unexpected result for link", 64'(out_ch.link_index_out), '0);
      return;
    end
    want = pending_costs.pop_front();
    if (out_ch.link_index_out !== want.link_index)
      report_mismatch("link_index_out", 64'(out_ch.link_index_out), 64'(want.link_index));
    if (out_ch.congested_time !== want.congested_time)
      report_mismatch("congested_time", 64'(out_ch.congested_time),
                      64'(want.congested_time));
    if (out_ch.half_slope !== want.half_slope)
      report_mismatch("half_slope", 64'(out_ch.half_slope), 64'(want.half_slope));
    if (out_ch.intercept !== want.intercept)
      report_mismatch("intercept", 64'(unsigned'(out_ch.intercept)), 64'(want.intercept));
    if (out_ch.objective_total !== want.objective_total)
      report_mismatch("objective_total", 64'(out_ch.objective_total),
                      64'(want.objective_total));
    if (out_ch.total_valid !== want.total_valid)
      report_mismatch("total_valid", 64'(out_ch.total_valid), 64'(want.total_valid));
    if (out_ch.status !== want.status)
      report_mismatch("status", 64'(out_ch.status), 64'(want.status));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_cost();
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.link_index <= '0;
    in_ch.flow <= '0;
    in_ch.free_time <= '0;
    in_ch.alpha_coef <= '0;
    in_ch.beta_exp <= '0;
    in_ch.link_capacity <= '0;
    in_ch.last_link <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_links[k])
      send_link(corner_links[k].desc, corner_links[k].fixed_cost, corner_links[k].cost);

    for (int n = 0; n < RANDOM_LINKS; n++) begin
      if (n == RANDOM_LINKS / 3) begin
        src_idle_pct = 62;
        snk_idle_pct = 24;
      end else if (n == 2 * RANDOM_LINKS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      send_link(rand_link(), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_costs.size() != 0) @(posedge clk);
    // catch any stray transfer after the last result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
